[src/pgn_pkg.sv]
package pgn_pkg;

  // Default configuration of the noise block.
  localparam int TABLE_SIZE_DEF      = 256;
  localparam int COORD_FRAC_BITS_DEF = 16;

  // Fixed-point formats.
  localparam int FRAC_W    = 14;          // lattice offset and fade weight, Q0.14
  localparam int GRAD_W    = 16;          // one gradient component, Q1.14
  localparam int OFF_W     = FRAC_W + 1;  // signed corner offset
  localparam int MUL_W     = OFF_W + GRAD_W;
  localparam int LV_W      = 34;          // dot products and blended values, Q28
  localparam int PROD_W    = LV_W + 16;   // blend difference times weight
  localparam int W_W       = 16;          // fade term 3 - 2t in Q14
  localparam int THREE_Q14 = 3 << FRAC_W;
  localparam int OUT_W     = 16;

  // Operation codes on the input channel.
  typedef enum logic [1:0] {
    OP_EVAL    = 2'd0,
    OP_WR_PERM = 2'd1,
    OP_WR_GRAD = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // Class of a queued item.
  typedef enum logic [1:0] {
    KIND_EVAL = 2'd0,
    KIND_PERM = 2'd1,
    KIND_GRAD = 2'd2
  } kind_t;

endpackage

[src/pgn_front.sv]
module pgn_front #(
  parameter int TABLE_SIZE      = pgn_pkg::TABLE_SIZE_DEF,
  parameter int COORD_FRAC_BITS = pgn_pkg::COORD_FRAC_BITS_DEF,
  localparam int IDX_W          = $clog2(TABLE_SIZE)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_operation,
  input  logic signed [31:0]                    in_coord_x,
  input  logic signed [31:0]                    in_coord_y,
  input  logic signed [31:0]                    in_coord_z,
  input  logic [7:0]                            in_entry_index,
  input  logic [7:0]                            in_perm_value,
  input  logic signed [pgn_pkg::GRAD_W-1:0]     in_grad_x,
  input  logic signed [pgn_pkg::GRAD_W-1:0]     in_grad_y,
  input  logic signed [pgn_pkg::GRAD_W-1:0]     in_grad_z,
  output logic                                  q_valid,
  input  logic                                  q_pop,
  output pgn_pkg::kind_t                        q_kind,
  output logic [IDX_W-1:0]                      q_cx,
  output logic [IDX_W-1:0]                      q_cy,
  output logic [IDX_W-1:0]                      q_cz,
  output logic [pgn_pkg::FRAC_W-1:0]            q_fx,
  output logic [pgn_pkg::FRAC_W-1:0]            q_fy,
  output logic [pgn_pkg::FRAC_W-1:0]            q_fz,
  output logic [IDX_W-1:0]                      q_idx,
  output logic [7:0]                            q_pv,
  output logic [3*pgn_pkg::GRAD_W-1:0]          q_grad
);
  import pgn_pkg::*;

  localparam int FT_W = COORD_FRAC_BITS + FRAC_W;

  typedef struct packed {
    kind_t                 kind;
    logic [IDX_W-1:0]      cx;
    logic [IDX_W-1:0]      cy;
    logic [IDX_W-1:0]      cz;
    logic [FRAC_W-1:0]     fx;
    logic [FRAC_W-1:0]     fy;
    logic [FRAC_W-1:0]     fz;
    logic [IDX_W-1:0]      idx;
    logic [7:0]            pv;
    logic [3*GRAD_W-1:0]   grad;
  } entry_t;

  logic signed [31:0] crd [3];
  logic signed [31:0] shifted [3];
  logic [FT_W-1:0]    ftmp [3];
  logic [IDX_W-1:0]   cell_idx [3];
  logic [FRAC_W-1:0]  frac [3];
  logic [IDX_W+7:0]   idx_ext;
  entry_t             ent;
  kind_t              kind;
  entry_t             fifo_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;
  logic               accept;
  logic               push;

  assign crd[0] = in_coord_x;
  assign crd[1] = in_coord_y;
  assign crd[2] = in_coord_z;

  // Split each coordinate into its lattice cell (floor, wrapped) and a Q0.14 fraction.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      shifted[a]  = crd[a] >>> COORD_FRAC_BITS;
      cell_idx[a] = shifted[a][IDX_W-1:0];
      ftmp[a]     = {crd[a][COORD_FRAC_BITS-1:0], FRAC_W'(0)};
      frac[a]     = ftmp[a][FT_W-1:COORD_FRAC_BITS];
    end
  end

  // Classify the operation.
  always_comb begin
    case (in_operation)
      OP_EVAL:    kind = KIND_EVAL;
      OP_WR_PERM: kind = KIND_PERM;
      OP_WR_GRAD: kind = KIND_GRAD;
      default:    kind = KIND_EVAL;
    endcase
  end

  // The table index wraps at the table size.
  assign idx_ext = {{IDX_W{1'b0}}, in_entry_index};

  always_comb begin
    ent.kind = kind;
    ent.cx   = cell_idx[0];
    ent.cy   = cell_idx[1];
    ent.cz   = cell_idx[2];
    ent.fx   = frac[0];
    ent.fy   = frac[1];
    ent.fz   = frac[2];
    ent.idx  = idx_ext[IDX_W-1:0];
    ent.pv   = in_perm_value;
    ent.grad = {in_grad_x, in_grad_y, in_grad_z};
  end

  // Two-entry queue; the unused operation code is accepted and dropped.
  assign in_stall = (cnt_r == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (in_operation != OP_UNUSED);
  assign cnt_nxt  = cnt_r + 2'(push) - 2'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= ent;
    end
  end

  // Queue head toward the back end.
  assign q_valid = (cnt_r != 2'd0);
  assign q_kind  = fifo_r[rd_ptr_r].kind;
  assign q_cx    = fifo_r[rd_ptr_r].cx;
  assign q_cy    = fifo_r[rd_ptr_r].cy;
  assign q_cz    = fifo_r[rd_ptr_r].cz;
  assign q_fx    = fifo_r[rd_ptr_r].fx;
  assign q_fy    = fifo_r[rd_ptr_r].fy;
  assign q_fz    = fifo_r[rd_ptr_r].fz;
  assign q_idx   = fifo_r[rd_ptr_r].idx;
  assign q_pv    = fifo_r[rd_ptr_r].pv;
  assign q_grad  = fifo_r[rd_ptr_r].grad;

endmodule

[src/pgn_back.sv]
module pgn_back #(
  parameter int TABLE_SIZE = pgn_pkg::TABLE_SIZE_DEF,
  localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  output logic                               q_pop,
  input  pgn_pkg::kind_t                     q_kind,
  input  logic [IDX_W-1:0]                   q_cx,
  input  logic [IDX_W-1:0]                   q_cy,
  input  logic [IDX_W-1:0]                   q_cz,
  input  logic [pgn_pkg::FRAC_W-1:0]         q_fx,
  input  logic [pgn_pkg::FRAC_W-1:0]         q_fy,
  input  logic [pgn_pkg::FRAC_W-1:0]         q_fz,
  input  logic [IDX_W-1:0]                   q_idx,
  input  logic [7:0]                         q_pv,
  input  logic [3*pgn_pkg::GRAD_W-1:0]       q_grad,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pgn_pkg::OUT_W-1:0]   out_noise_value
);
  import pgn_pkg::*;

  localparam int NST = 11;

  // Pipeline control.
  logic                     en;
  logic [NST:1]             vld_r;
  kind_t                    kind1_r;
  kind_t                    kind2_r;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_val_r;

  // Stage 1.
  logic [7:0]               permA [TABLE_SIZE];
  logic [7:0]               pi_r;
  logic [7:0]               pj_r;
  logic [IDX_W-1:0]         cy1_r;
  logic [IDX_W-1:0]         cz1_r;
  logic [FRAC_W-1:0]        f1_r [3];
  logic [IDX_W-1:0]         idx1_r;
  logic [7:0]               pv1_r;
  logic [3*GRAD_W-1:0]      grad1_r;
  logic [FRAC_W-1:0]        qf [3];
  logic [2*FRAC_W-1:0]      sq [3];
  logic [FRAC_W-1:0]        t2_r [3];
  logic [W_W-1:0]           w_r [3];

  // Stage 2.
  logic [7:0]               permB [TABLE_SIZE];
  logic [7:0]               permC [TABLE_SIZE];
  logic [7:0]               b_r [4];
  logic [IDX_W-1:0]         cz2_r;
  logic [FRAC_W-1:0]        f2_r [3];
  logic [IDX_W-1:0]         idx2_r;
  logic [3*GRAD_W-1:0]      grad2_r;
  logic [FRAC_W+W_W-1:0]    sw [3];
  logic [FRAC_W:0]          s_pipe_r [2:9][3];

  // Stage 3 and later.
  logic [3*GRAD_W-1:0]      gr_q [8];
  logic [FRAC_W-1:0]        f3_r [3];
  logic signed [OFF_W-1:0]  off0 [3];
  logic signed [OFF_W-1:0]  off1 [3];
  logic signed [MUL_W-1:0]  mul_r [8][3];
  logic signed [LV_W-1:0]   dot_r [8];
  logic signed [PROD_W-1:0] xp_r [4];
  logic signed [LV_W-1:0]   xa_r [4];
  logic signed [LV_W-1:0]   lx_r [4];
  logic signed [PROD_W-1:0] yp_r [2];
  logic signed [LV_W-1:0]   ya_r [2];
  logic signed [LV_W-1:0]   ly_r [2];
  logic signed [PROD_W-1:0] zp_r;
  logic signed [LV_W-1:0]   za_r;
  logic signed [LV_W-1:0]   lz_r;
  logic signed [LV_W-15:0]  fin;

  // Table index plus a permutation value, wrapped at the table size.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [7:0] p,
                                                input logic [IDX_W-1:0] c);
    logic [IDX_W+7:0] sum;
    sum = {{IDX_W{1'b0}}, p} + {8'd0, c};
    return sum[IDX_W-1:0];
  endfunction

  // Weight times the difference of the two blend inputs.
  function automatic logic signed [PROD_W-1:0] lerp_mul(input logic signed [LV_W-1:0] a,
                                                        input logic signed [LV_W-1:0] b,
                                                        input logic [FRAC_W:0] s);
    logic signed [LV_W-1:0] d;
    logic signed [15:0]     sv;
    d  = b - a;
    sv = $signed({1'b0, s});
    return d * sv;
  endfunction

  // Add the floored scaled difference back to the first input.
  function automatic logic signed [LV_W-1:0] lerp_add(input logic signed [LV_W-1:0] a,
                                                      input logic signed [PROD_W-1:0] p);
    return a + $signed(p[LV_W+FRAC_W-1:FRAC_W]);
  endfunction

  // The whole pipe advances whenever the output register can take a beat.
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[1]    <= q_valid;
      vld_r[2]    <= vld_r[1];
      vld_r[3]    <= vld_r[2] && (kind2_r == KIND_EVAL);
      for (int k = 4; k <= NST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[NST];
    end
  end

  // Stage 1: first permutation lookup and the square of each fraction.
  assign qf[0] = q_fx;
  assign qf[1] = q_fy;
  assign qf[2] = q_fz;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sq[a] = qf[a] * qf[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (q_valid && (q_kind == KIND_PERM)) begin
        permA[q_idx] <= q_pv;
      end
      pi_r    <= permA[q_cx];
      pj_r    <= permA[q_cx + IDX_W'(1)];
      kind1_r <= q_kind;
      cy1_r   <= q_cy;
      cz1_r   <= q_cz;
      idx1_r  <= q_idx;
      pv1_r   <= q_pv;
      grad1_r <= q_grad;
      for (int a = 0; a < 3; a++) begin
        f1_r[a] <= qf[a];
        t2_r[a] <= sq[a][2*FRAC_W-1:FRAC_W];
        w_r[a]  <= W_W'(THREE_Q14) - {1'b0, qf[a], 1'b0};
      end
    end
  end

  // Stage 2: second permutation lookups and the fade weights.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sw[a] = t2_r[a] * w_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (vld_r[1] && (kind1_r == KIND_PERM)) begin
        permB[idx1_r] <= pv1_r;
        permC[idx1_r] <= pv1_r;
      end
      b_r[0]  <= permB[wrap_add(pi_r, cy1_r)];
      b_r[2]  <= permB[wrap_add(pi_r, cy1_r + IDX_W'(1))];
      b_r[1]  <= permC[wrap_add(pj_r, cy1_r)];
      b_r[3]  <= permC[wrap_add(pj_r, cy1_r + IDX_W'(1))];
      kind2_r <= kind1_r;
      cz2_r   <= cz1_r;
      idx2_r  <= idx1_r;
      grad2_r <= grad1_r;
      for (int a = 0; a < 3; a++) begin
        f2_r[a]        <= f1_r[a];
        s_pipe_r[2][a] <= sw[a][2*FRAC_W:FRAC_W];
      end
      // Weights ride along until the blend that needs them.
      for (int k = 3; k <= 9; k++) begin
        s_pipe_r[k] <= s_pipe_r[k-1];
      end
    end
  end

  // Stage 3: gradient lookups, one table copy for each x/y corner pair.
  for (genvar g = 0; g < 4; g++) begin : g_grad
    logic [3*GRAD_W-1:0] gmem [TABLE_SIZE];
    logic [3*GRAD_W-1:0] rd0_r;
    logic [3*GRAD_W-1:0] rd1_r;

    always_ff @(posedge clk) begin
      if (en) begin
        if (vld_r[2] && (kind2_r == KIND_GRAD)) begin
          gmem[idx2_r] <= grad2_r;
        end
        rd0_r <= gmem[wrap_add(b_r[g], cz2_r)];
        rd1_r <= gmem[wrap_add(b_r[g], cz2_r + IDX_W'(1))];
      end
    end

    assign gr_q[g]     = rd0_r;
    assign gr_q[g + 4] = rd1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_r <= f2_r;
    end
  end

  // Stage 4: offset times gradient component for all eight corners.
  // The far-corner offset r - 1.0 is the fraction with the sign bit set.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      off0[a] = $signed({1'b0, f3_r[a]});
      off1[a] = $signed({1'b1, f3_r[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 8; n++) begin
        mul_r[n][0] <= (n[0] ? off1[0] : off0[0]) * $signed(gr_q[n][3*GRAD_W-1:2*GRAD_W]);
        mul_r[n][1] <= (n[1] ? off1[1] : off0[1]) * $signed(gr_q[n][2*GRAD_W-1:GRAD_W]);
        mul_r[n][2] <= (n[2] ? off1[2] : off0[2]) * $signed(gr_q[n][GRAD_W-1:0]);
      end
    end
  end

  // Stage 5: dot products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 8; n++) begin
        dot_r[n] <= LV_W'(mul_r[n][0]) + LV_W'(mul_r[n][1]) + LV_W'(mul_r[n][2]);
      end
    end
  end

  // Stages 6 to 11: blend along x, then y, then z.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 4; m++) begin
        xp_r[m] <= lerp_mul(dot_r[2*m], dot_r[2*m+1], s_pipe_r[5][0]);
        xa_r[m] <= dot_r[2*m];
        lx_r[m] <= lerp_add(xa_r[m], xp_r[m]);
      end
      for (int m = 0; m < 2; m++) begin
        yp_r[m] <= lerp_mul(lx_r[2*m], lx_r[2*m+1], s_pipe_r[7][1]);
        ya_r[m] <= lx_r[2*m];
        ly_r[m] <= lerp_add(ya_r[m], yp_r[m]);
      end
      zp_r <= lerp_mul(ly_r[0], ly_r[1], s_pipe_r[9][2]);
      za_r <= ly_r[0];
      lz_r <= lerp_add(za_r, zp_r);
    end
  end

  // Output register: back to Q1.14, saturated.
  assign fin = lz_r[LV_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin > $signed(20'sd32767)) begin
        out_val_r <= 16'sh7FFF;
      end else if (fin < $signed(-20'sd32768)) begin
        out_val_r <= 16'sh8000;
      end else begin
        out_val_r <= fin[OUT_W-1:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_val_r;

endmodule

[src/perlin_gradient_noise_3d_top.sv]
// Channel   Ports                                         Beat moves
// input     in_valid / in_stall, in_operation, in_coord_*,  one evaluate or table write
//           in_entry_index, in_perm_value, in_grad_*
// output    out_valid / out_stall, out_noise_value         one noise value (Q1.14)
//
// One item is taken every cycle while the output does not stall; an evaluate passes
// through the queue, the back-end stages and the output register. The rate is set
// by the fully pipelined back end, with replicated permutation and gradient tables
// so that the lookups of one point at each level run side by side. Table writes go
// down the same pipe and land in each table copy at its lookup stage, so evaluates
// see writes in order. Reset (synchronous, rst_n low) empties the queue and the
// pipe; tables are not cleared. A stall on the output while out_valid is high
// freezes the back end; the two-entry queue then fills and raises in_stall.
module perlin_gradient_noise_3d_top #(
  parameter int TABLE_SIZE      = pgn_pkg::TABLE_SIZE_DEF,
  parameter int COORD_FRAC_BITS = pgn_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_operation,
  input  logic signed [31:0]                 in_coord_x,
  input  logic signed [31:0]                 in_coord_y,
  input  logic signed [31:0]                 in_coord_z,
  input  logic [7:0]                         in_entry_index,
  input  logic [7:0]                         in_perm_value,
  input  logic signed [pgn_pkg::GRAD_W-1:0]  in_grad_x,
  input  logic signed [pgn_pkg::GRAD_W-1:0]  in_grad_y,
  input  logic signed [pgn_pkg::GRAD_W-1:0]  in_grad_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pgn_pkg::OUT_W-1:0]   out_noise_value
);
  import pgn_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);

  logic                  q_valid;
  logic                  q_pop;
  kind_t                 q_kind;
  logic [IDX_W-1:0]      q_cx;
  logic [IDX_W-1:0]      q_cy;
  logic [IDX_W-1:0]      q_cz;
  logic [FRAC_W-1:0]     q_fx;
  logic [FRAC_W-1:0]     q_fy;
  logic [FRAC_W-1:0]     q_fz;
  logic [IDX_W-1:0]      q_idx;
  logic [7:0]            q_pv;
  logic [3*GRAD_W-1:0]   q_grad;

  // Front end: accept, split coordinates, queue.
  pgn_front #(
    .TABLE_SIZE      (TABLE_SIZE),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_entry_index (in_entry_index),
    .in_perm_value  (in_perm_value),
    .in_grad_x      (in_grad_x),
    .in_grad_y      (in_grad_y),
    .in_grad_z      (in_grad_z),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_kind         (q_kind),
    .q_cx           (q_cx),
    .q_cy           (q_cy),
    .q_cz           (q_cz),
    .q_fx           (q_fx),
    .q_fy           (q_fy),
    .q_fz           (q_fz),
    .q_idx          (q_idx),
    .q_pv           (q_pv),
    .q_grad         (q_grad)
  );

  // Back end: table lookups, dot products and blending.
  pgn_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_kind          (q_kind),
    .q_cx            (q_cx),
    .q_cy            (q_cy),
    .q_cz            (q_cz),
    .q_fx            (q_fx),
    .q_fy            (q_fy),
    .q_fz            (q_fz),
    .q_idx           (q_idx),
    .q_pv            (q_pv),
    .q_grad          (q_grad),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_noise_value (out_noise_value)
  );

endmodule
